// ===== hw/rtl/c3mc_pkg.sv =====
// Shared types and constants for the 3x3 multichannel convolution core.
// Holds the field widths, the func codes and the sequencer state type.
// No dependencies.
package c3mc_pkg;

  // Item field widths
  localparam int FUNC_W   = 2;
  localparam int OCH_W    = 4;
  localparam int ICH_W    = 3;
  localparam int POS_W    = 4;
  localparam int DATA_W   = 16;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int SUM_W    = 41;

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 8;
  localparam int M_TDATA_W = 48;

  // func codes
  localparam logic [FUNC_W-1:0] FUNC_WR_WEIGHT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_ACT    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RD_OUT    = 2'd2;

  // Read sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

// ===== hw/rtl/c3mc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the weight and activation stores. No dependencies.
module c3mc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1152
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/conv_3x3_multichannel_core.sv =====
// Multichannel 2-D valid convolution core, stride 1, square kernels.
// Writes: a write transaction lands in its store at the accepting edge, one per
// cycle while the core is idle. A read steps the single shared MAC through every
// tap, drains the MAC pipeline and then loads the result register; no new item
// is taken until that load. An out-of-range read skips the taps and returns zero.
// Reset: rst_ni async active low clears sequencer and handshake state; the stores
// are not cleared and hold undefined data until written.
module conv_3x3_multichannel_core
  import c3mc_pkg::*;
#(
  parameter int IN_CHANNELS  = 8,
  parameter int OUT_CHANNELS = 16,
  parameter int KERNEL_SIZE  = 3,
  parameter int IN_SIZE      = 12,
  parameter int OUT_SIZE     = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input item stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: out_chan[3:0], in_chan[6:4], row_pos[10:7], col_pos[14:11],
  //        data_value[30:15], zero[31]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // tuser: func[1:0], zero[7:2]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: conv_sum[40:0], zero[47:41]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  // Store geometry
  localparam int KK      = KERNEL_SIZE * KERNEL_SIZE;
  localparam int W_DEPTH = OUT_CHANNELS * IN_CHANNELS * KK;
  localparam int A_DEPTH = IN_CHANNELS * IN_SIZE * IN_SIZE;
  localparam int WAW     = W_DEPTH > 1 ? $clog2(W_DEPTH) : 1;
  localparam int AAW     = A_DEPTH > 1 ? $clog2(A_DEPTH) : 1;
  // Tap counters
  localparam int ICW     = IN_CHANNELS > 1 ? $clog2(IN_CHANNELS) : 1;
  localparam int KW      = KERNEL_SIZE > 1 ? $clog2(KERNEL_SIZE) : 1;
  // Width of row_pos + kernel row (and columns alike)
  localparam int PW      = (KW > POS_W ? KW : POS_W) + 1;

  // ---------------------------------------------------------------------------
  // Input field unpacking
  // ---------------------------------------------------------------------------
  logic [FUNC_W-1:0] in_func;
  logic [OCH_W-1:0]  in_och;
  logic [ICH_W-1:0]  in_ich;
  logic [POS_W-1:0]  in_row;
  logic [POS_W-1:0]  in_col;
  logic [DATA_W-1:0] in_data;

  assign in_func = s_axis_tuser[1:0];
  assign in_och  = s_axis_tdata[3:0];
  assign in_ich  = s_axis_tdata[6:4];
  assign in_row  = s_axis_tdata[10:7];
  assign in_col  = s_axis_tdata[14:11];
  assign in_data = s_axis_tdata[30:15];

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Range checks, same rules as the store layout
  logic w_in_range, a_in_range, rd_in_range;
  assign w_in_range  = (32'(in_och) < OUT_CHANNELS) && (32'(in_ich) < IN_CHANNELS) &&
                       (32'(in_row) < KERNEL_SIZE) && (32'(in_col) < KERNEL_SIZE);
  assign a_in_range  = (32'(in_ich) < IN_CHANNELS) && (32'(in_row) < IN_SIZE) &&
                       (32'(in_col) < IN_SIZE);
  assign rd_in_range = (32'(in_och) < OUT_CHANNELS) && (32'(in_row) < OUT_SIZE) &&
                       (32'(in_col) < OUT_SIZE);

  // Write addresses: weights are [oc][ic][kr][kc], activations [ic][row][col]
  logic [WAW-1:0] w_wr_addr;
  logic [AAW-1:0] a_wr_addr;
  assign w_wr_addr = WAW'(32'(in_och) * (IN_CHANNELS * KK) + 32'(in_ich) * KK +
                          32'(in_row) * KERNEL_SIZE + 32'(in_col));
  assign a_wr_addr = AAW'(32'(in_ich) * (IN_SIZE * IN_SIZE) + 32'(in_row) * IN_SIZE +
                          32'(in_col));

  // Base of the weight block for a read's output channel
  logic [WAW-1:0] w_rd_base;
  assign w_rd_base = WAW'(32'(in_och) * (IN_CHANNELS * KK));

  // ---------------------------------------------------------------------------
  // Sequencer state and decode
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic is_read, w_we, a_we;
  always_comb begin
    is_read = 1'b0;
    w_we    = 1'b0;
    a_we    = 1'b0;
    unique case (in_func)
      FUNC_WR_WEIGHT: w_we    = accept && w_in_range;
      FUNC_WR_ACT:    a_we    = accept && a_in_range;
      FUNC_RD_OUT:    is_read = accept;
      default: ;      // unused code: dropped, no result
    endcase
  end

  // Tap counters: kc fastest, then kr, then ic
  logic [ICW-1:0] ic_q, ic_d;
  logic [KW-1:0]  kr_q, kr_d, kc_q, kc_d;
  logic [WAW-1:0] w_rd_addr_q, w_rd_addr_d;
  logic [POS_W-1:0] row_q, col_q;
  logic           last_tap;

  assign last_tap = (32'(ic_q) == IN_CHANNELS - 1) && (32'(kr_q) == KERNEL_SIZE - 1) &&
                    (32'(kc_q) == KERNEL_SIZE - 1);

  // MAC pipeline: issue -> RAM data (v1) -> product (v2) -> accumulator
  logic v1_q, tap_ok1_q, v2_q;
  logic out_valid_q;
  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_read) begin
          state_d = rd_in_range ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (last_tap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  logic issue, load_out;
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_RUN:   issue         = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  load_out      = out_free;
      default: ;
    endcase
  end

  // Counter and read-address stepping
  always_comb begin
    ic_d        = ic_q;
    kr_d        = kr_q;
    kc_d        = kc_q;
    w_rd_addr_d = w_rd_addr_q;
    if (is_read) begin
      ic_d        = '0;
      kr_d        = '0;
      kc_d        = '0;
      w_rd_addr_d = w_rd_base;
    end else if (issue) begin
      w_rd_addr_d = w_rd_addr_q + WAW'(1);
      if (32'(kc_q) == KERNEL_SIZE - 1) begin
        kc_d = '0;
        if (32'(kr_q) == KERNEL_SIZE - 1) begin
          kr_d = '0;
          ic_d = ic_q + ICW'(1);
        end else begin
          kr_d = kr_q + KW'(1);
        end
      end else begin
        kc_d = kc_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Counters only matter while a read runs; no reset needed
  always_ff @(posedge clk_i) begin
    ic_q        <= ic_d;
    kr_q        <= kr_d;
    kc_q        <= kc_d;
    w_rd_addr_q <= w_rd_addr_d;
    if (is_read) begin
      row_q <= in_row;
      col_q <= in_col;
    end
  end

  // Activation tap position; taps that fall off the map add nothing
  logic [PW-1:0]  act_row, act_col;
  logic           tap_ok;
  logic [AAW-1:0] a_rd_addr;
  assign act_row   = PW'(row_q) + PW'(kr_q);
  assign act_col   = PW'(col_q) + PW'(kc_q);
  assign tap_ok    = (32'(act_row) < IN_SIZE) && (32'(act_col) < IN_SIZE);
  assign a_rd_addr = AAW'(32'(ic_q) * (IN_SIZE * IN_SIZE) + 32'(act_row) * IN_SIZE +
                          32'(act_col));

  logic rd_en;
  assign rd_en = issue && tap_ok;

  // ---------------------------------------------------------------------------
  // Stores. Writes are taken only in IDLE and reads issued only in RUN, so the
  // two ports never touch the same entry in one cycle.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] w_rdata, a_rdata;

  c3mc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (W_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_wr_addr),
    .wdata_i (in_data),
    .re_i    (rd_en),
    .raddr_i (w_rd_addr_q),
    .rdata_o (w_rdata)
  );

  c3mc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (A_DEPTH)
  ) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_wr_addr),
    .wdata_i (in_data),
    .re_i    (rd_en),
    .raddr_i (a_rd_addr),
    .rdata_o (a_rdata)
  );

  // ---------------------------------------------------------------------------
  // Shared MAC: one 16x16 multiply per cycle, registered, then accumulate
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic        [SUM_W-1:0]  acc_q;
  logic        [SUM_W-1:0]  out_q;

  // signed 16x16 product, both operands sign-extended
  assign prod_d = signed'(w_rdata) * signed'(a_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tap_ok1_q <= tap_ok;
    if (v1_q) begin
      prod_q <= tap_ok1_q ? prod_d : '0;
    end
    // accumulator wraps; only the low SUM_W bits are ever returned
    if (is_read) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
    if (load_out) begin
      out_q <= acc_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - SUM_W){1'b0}}, out_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // MAC pipeline is empty whenever a new item can be taken
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!v1_q && !v2_q))
    else $error("MAC pipeline busy in IDLE");

  // Result always lands in the output register when DONE finds it free
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("finished read not delivered to output register");

  // Sequenced reads stay inside both stores
  a_w_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (32'(w_rd_addr_q) < W_DEPTH))
    else $error("weight read address out of range");

  a_a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (32'(a_rd_addr) < A_DEPTH))
    else $error("activation read address out of range");

  // No store write while a read is being sequenced
  a_no_wr_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (!w_we && !a_we))
    else $error("store write during read sequence");

endmodule
